// ===== sv/lru_key_value_cache_defines.svh =====
// Assertion helpers used by the datapath RTL file of the key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define LKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition holds whenever an update command is issued.
`define LKVC_ASSERT_ON_UPDATE(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cmd_i.update |-> (cond))) else $error(msg);

`endif

// ===== sv/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned KEY_BITS        = 32;
  localparam int unsigned VALUE_BITS      = 32;
  localparam int unsigned CAP_BITS        = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   opcode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] data;
    logic                  inserted;
  } rsp_t;

  // Commands from the sequencer to the datapath, one per phase of a request.
  typedef struct packed {
    logic latch;
    logic compare;
    logic encode;
    logic update;
  } cmd_t;

endpackage

// ===== sv/lkvc_ctrl.sv =====
module lkvc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output lkvc_pkg::cmd_t cmd_o
);
  import lkvc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_ENC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_RSP  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP:   state_d = S_ENC;
      S_ENC:   state_d = S_UPD;
      S_UPD:   state_d = S_RSP;
      S_RSP:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_RSP);
  assign cmd_o.latch   = (state_q == S_IDLE) && start_i;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.encode  = (state_q == S_ENC);
  assign cmd_o.update  = (state_q == S_UPD);

endmodule

// ===== sv/lkvc_datapath.sv =====
`include "lru_key_value_cache_defines.svh"

module lkvc_datapath #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lkvc_pkg::cmd_t                 cmd_i,
  input  lkvc_pkg::req_t                 req_i,
  input  logic                           cfg_we_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0]  cfg_wdata_i,
  output lkvc_pkg::rsp_t                 rsp_o
);
  import lkvc_pkg::*;

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = ((CW > CAP_BITS) ? CW : CAP_BITS) + 1;

  // Returns {found, index} of the lowest set bit.
  function automatic logic [IW:0] first_set(input logic [ENTRIES-1:0] vec);
    logic [IW:0] res;
    res = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res = {1'b1, IW'(i)};
      end
    end
    return res;
  endfunction

  req_t                  req_q;
  logic [CAP_BITS-1:0]   capacity_q;
  logic [ENTRIES-1:0]    valid_q;
  logic [CW-1:0]         count_q;
  logic [IW-1:0]         rank_q [ENTRIES];
  logic [KEY_BITS-1:0]   key_q  [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];

  logic [ENTRIES-1:0]    match_q, free_q, old_q;
  logic                  hit_found_q, free_found_q, old_found_q;
  logic [IW-1:0]         hit_idx_q, free_idx_q, old_idx_q, hit_rank_q;
  logic                  over_cap_q, count_zero_q;
  logic                  found_q, inserted_q;
  logic [VALUE_BITS-1:0] rd_q;

  logic [IW:0]           hit_enc, free_enc, old_enc;
  logic [CMPW-1:0]       cap_eff;
  logic                  is_lookup, lookup_hit;
  logic                  ins_go, cnt_inc, evict_old, drop_new;
  logic [IW-1:0]         tgt_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
  end

  // Compare phase: one comparator per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= valid_q[i] && (key_q[i] == req_q.key);
        free_q[i]  <= !valid_q[i];
        old_q[i]   <= valid_q[i] &&
                      ((CMPW'(rank_q[i]) + CMPW'(1)) == CMPW'(count_q));
      end
    end
  end

  // Encode phase: priority encoders and the capacity check.
  assign hit_enc  = first_set(match_q);
  assign free_enc = first_set(free_q);
  assign old_enc  = first_set(old_q);
  assign cap_eff  = (CMPW'(capacity_q) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES)
                                                          : CMPW'(capacity_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.encode) begin
      hit_found_q  <= hit_enc[IW];
      hit_idx_q    <= hit_enc[IW-1:0];
      free_found_q <= free_enc[IW];
      free_idx_q   <= free_enc[IW-1:0];
      old_found_q  <= old_enc[IW];
      old_idx_q    <= old_enc[IW-1:0];
      hit_rank_q   <= rank_q[hit_enc[IW-1:0]];
      over_cap_q   <= (CMPW'(count_q) + CMPW'(1)) > cap_eff;
      count_zero_q <= (count_q == '0);
    end
  end

  // Update phase decisions.
  always_comb begin
    is_lookup  = (req_q.opcode == OP_LOOKUP);
    lookup_hit = is_lookup && hit_found_q;
    ins_go     = 1'b0;
    cnt_inc    = 1'b0;
    evict_old  = 1'b0;
    drop_new   = 1'b0;
    tgt_idx    = free_idx_q;
    if (!is_lookup && !hit_found_q) begin
      if (free_found_q) begin
        // New entry takes a free slot; a full store drops its oldest entry,
        // and an empty store with no room drops the new entry itself.
        ins_go    = 1'b1;
        drop_new  = over_cap_q && count_zero_q;
        evict_old = over_cap_q && !count_zero_q && old_found_q;
        cnt_inc   = !(drop_new || evict_old);
      end else if (old_found_q) begin
        // Every slot in use: the oldest entry is replaced in place.
        ins_go  = 1'b1;
        tgt_idx = old_idx_q;
      end
    end
  end

  // Each slot picks its own next valid bit and rank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (lookup_hit) begin
          if (IW'(i) == hit_idx_q) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end else if (ins_go) begin
          if (IW'(i) == tgt_idx) begin
            valid_q[i] <= !drop_new;
            rank_q[i]  <= '0;
          end else if (evict_old && (IW'(i) == old_idx_q)) begin
            valid_q[i] <= 1'b0;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end
      end
      if (ins_go && cnt_inc) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && ins_go) begin
      key_q[tgt_idx] <= req_q.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (ins_go) begin
        value_mem[tgt_idx] <= req_q.value;
      end
      rd_q <= value_mem[hit_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      found_q    <= lookup_hit;
      inserted_q <= ins_go;
    end
  end

  assign rsp_o.found    = found_q;
  assign rsp_o.data     = found_q ? rd_q : '0;
  assign rsp_o.inserted = inserted_q;

  `LKVC_ASSERT(a_count_matches_valid, ($countones(valid_q) == int'(count_q)),
               "entry count differs from number of valid entries")
  `LKVC_ASSERT(a_count_bounded, (CMPW'(count_q) <= CMPW'(ENTRIES)),
               "entry count above store size")
  `LKVC_ASSERT_ON_UPDATE(a_unique_hit, $onehot0(match_q),
                         "key held in more than one entry")

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Channel   Direction  Handshake                     Payload
// request   in         start high while busy low     req_i   (opcode, key, value)
// result    out        done_o high for one cycle     rsp_o   (found, data, inserted)
// config    in         cfg_we_i high                 cfg_wdata_i (capacity)
//
// A request runs through compare, encode, update, then the result is shown for one
// cycle while busy is still high, and busy is low again for the cycle whose closing
// edge can accept the next request. The result strobe comes from the response state.
// The chain of key compare, priority encode and the recency update sets these phases.
// Reset clears all valid bits, recency ranks and the entry count at once, so no
// clearing pass is needed. The receiver cannot stall.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lkvc_pkg::req_t                req_i,
  output logic                          done_o,
  output lkvc_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  // The sequencer issues one command per phase; the datapath holds the store.
  cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // The datapath keeps keys in flip-flops for the parallel compare and the
  // values in a small memory that is read only at the hit slot.
  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== test/tb_lru_key_value_cache.sv =====
`timescale 1ns / 100ps

// Self-checking testbench for the LRU key-value cache.
//
// A list of steps is built up front. A step is a request, a capacity write, a run of idle
// cycles, or a pause until the cache has answered everything. A clocked driver works through
// that list on the falling clock edge. A clocked monitor runs on the rising edge. It watches
// requests being accepted and capacity writes landing, and it runs them through a behavioral
// copy of the cache to get the response that the cache should return. It then checks each
// done_o pulse against the oldest pending prediction.
module tb_lru_key_value_cache;

  localparam int unsigned SLOTS           = lkvc_pkg::ENTRIES_DEFAULT;
  localparam int unsigned ITEMS_PER_PHASE = 152;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned TAIL_CYCLES     = 12;
  localparam int unsigned MAX_PRINTED     = 30;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_IDLE,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e                    kind;
    lkvc_pkg::req_t                req;
    logic [lkvc_pkg::CAP_BITS-1:0] cap;
    int unsigned                   cycles;
  } step_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic                          busy;
  lkvc_pkg::req_t                req_i       = '0;
  logic                          done_o;
  lkvc_pkg::rsp_t                rsp_o;
  logic                          cfg_we_i    = 1'b0;
  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata_i = '0;

  lru_key_value_cache #(
    .ENTRIES(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The steps that are still to be driven, and the responses that are still to come back.
  step_t          pending_steps[$];
  lkvc_pkg::rsp_t expected_rsp[$];

  // This is the behavioral copy of the cache. Its slot ages mirror the recency ranks: 0 is the
  // most recent entry, and live_count-1 is the least recent valid entry.
  logic                          slot_valid[SLOTS];
  logic [lkvc_pkg::KEY_BITS-1:0]   slot_key[SLOTS];
  logic [lkvc_pkg::VALUE_BITS-1:0] slot_value[SLOTS];
  int unsigned                   slot_age[SLOTS];
  int unsigned                   live_count  = 0;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_setting = lkvc_pkg::CAP_RESET;

  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned hit_count      = 0;
  int unsigned miss_count     = 0;
  int unsigned stored_count   = 0;
  int unsigned rejected_count = 0;
  int unsigned cap_writes     = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_age[i]   = 0;
    end
  end

  task automatic note_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // This returns the slot that holds the least recent valid entry, or -1 when the store is
  // empty.
  function automatic int oldest_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && slot_age[i] + 1 == live_count) return i;
    end
    return -1;
  endfunction

  function automatic void drop_oldest();
    int s;
    s = oldest_slot();
    if (s >= 0) begin
      slot_valid[s] = 1'b0;
      slot_age[s]   = 0;
      live_count--;
    end
  endfunction

  // This applies one request to the behavioral copy and returns the response that the cache
  // has to give for it.
  function automatic lkvc_pkg::rsp_t cache_predict_rsp(lkvc_pkg::req_t r);
    lkvc_pkg::rsp_t res;
    int             hit;
    int             free_at;
    int unsigned    lim;
    logic           was_full;
    res     = '0;
    hit     = -1;
    free_at = -1;
    // A capacity above the number of slots behaves like a full-sized store.
    lim     = (cap_setting > SLOTS) ? SLOTS : cap_setting;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) begin
        if (slot_key[i] == r.key && hit < 0) hit = i;
      end else if (free_at < 0) begin
        free_at = i;
      end
    end

    if (r.opcode == lkvc_pkg::OP_LOOKUP) begin
      // A hit makes the entry the most recent, and a miss returns zero data.
      if (hit >= 0) begin
        res.found = 1'b1;
        res.data  = slot_value[hit];
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_age[i] < slot_age[hit]) slot_age[i]++;
        end
        slot_age[hit] = 0;
      end
      return res;
    end

    // An insert of a key that is already held touches neither the value nor the recency.
    if (hit >= 0) return res;

    // When every slot is in use, the least recent entry gives up its slot to the new key.
    was_full = (free_at < 0);
    if (was_full) begin
      free_at = oldest_slot();
      drop_oldest();
      if (free_at < 0) return res;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) slot_age[i]++;
    end
    slot_valid[free_at] = 1'b1;
    slot_key[free_at]   = r.key;
    slot_value[free_at] = r.value;
    slot_age[free_at]   = 0;
    live_count++;
    // Above the capacity, exactly one entry goes. With capacity 0 on an empty store, that entry
    // is the new one.
    if (!was_full && live_count > lim) drop_oldest();
    res.inserted = 1'b1;
    return res;
  endfunction

  task automatic queue_req(lkvc_pkg::op_e op, logic [lkvc_pkg::KEY_BITS-1:0] k,
                           logic [lkvc_pkg::VALUE_BITS-1:0] v);
    step_t s;
    s.kind       = STEP_REQ;
    s.req.opcode = op;
    s.req.key    = k;
    s.req.value  = v;
    s.cap        = '0;
    s.cycles     = 0;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  task automatic queue_cfg(logic [lkvc_pkg::CAP_BITS-1:0] c);
    step_t s;
    s.kind   = STEP_CFG;
    s.req    = '0;
    s.cap    = c;
    s.cycles = 0;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  task automatic queue_idle(int unsigned n);
    step_t s;
    s.kind   = STEP_IDLE;
    s.req    = '0;
    s.cap    = '0;
    s.cycles = n;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  task automatic queue_drain();
    step_t s;
    s.kind   = STEP_DRAIN;
    s.req    = '0;
    s.cap    = '0;
    s.cycles = 0;
    pending_steps.insert(pending_steps.size(), s);
  endtask

  // The driver changes the inputs on the falling edge. A request stays on the bus until a
  // rising edge sees start high and busy low. The next request may follow with start held high.
  // Capacity writes and drain steps wait until the cache is idle, with nothing outstanding.
  always @(negedge clk_i) begin : drive_requests
    logic                          start_n;
    lkvc_pkg::req_t                req_n;
    logic                          we_n;
    logic [lkvc_pkg::CAP_BITS-1:0] wdata_n;
    start_n = start;
    req_n   = req_i;
    we_n    = 1'b0;
    wdata_n = cfg_wdata_i;
    if (rst_ni && !(start && issued_count != accepted_count)) begin
      start_n = 1'b0;
      if (pending_steps.size() != 0) begin
        case (pending_steps[0].kind)
          STEP_REQ: begin
            start_n = 1'b1;
            req_n   = pending_steps[0].req;
            issued_count++;
            pending_steps.delete(0);
          end
          STEP_IDLE: begin
            if (pending_steps[0].cycles > 1) begin
              pending_steps[0].cycles = pending_steps[0].cycles - 1;
            end else begin
              pending_steps.delete(0);
            end
          end
          STEP_DRAIN: begin
            if (expected_rsp.size() == 0 && !busy) pending_steps.delete(0);
          end
          STEP_CFG: begin
            if (expected_rsp.size() == 0 && !busy) begin
              we_n    = 1'b1;
              wdata_n = pending_steps[0].cap;
              pending_steps.delete(0);
            end
          end
          default: pending_steps.delete(0);
        endcase
      end
    end
    start       <= start_n;
    req_i       <= req_n;
    cfg_we_i    <= we_n;
    cfg_wdata_i <= wdata_n;
  end

  // The monitor samples on the rising edge. Each result is checked before any request accepted
  // on the same edge is predicted, so the order of the predictions follows the cache.
  always @(posedge clk_i) begin : watch_cache
    lkvc_pkg::rsp_t want;
    lkvc_pkg::rsp_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        cap_setting = cfg_wdata_i;
        cap_writes++;
      end
      if (done_o) begin
        got = rsp_o;
        if (expected_rsp.size() == 0) begin
          note_mismatch($sformatf("result with no request outstanding: found=%b data=%h ins=%b",
                                  got.found, got.data, got.inserted));
        end else begin
          want = expected_rsp[0];
          expected_rsp.delete(0);
          if (got.found !== want.found)
            note_mismatch($sformatf("found: got %b, want %b", got.found, want.found));
          if (got.data !== want.data)
            note_mismatch($sformatf("data: got %h, want %h", got.data, want.data));
          if (got.inserted !== want.inserted)
            note_mismatch($sformatf("inserted: got %b, want %b", got.inserted, want.inserted));
        end
      end
      if (start && !busy) begin
        want = cache_predict_rsp(req_i);
        expected_rsp.insert(expected_rsp.size(), want);
        accepted_count++;
        if (req_i.opcode == lkvc_pkg::OP_LOOKUP) begin
          if (want.found) hit_count++;
          else miss_count++;
        end else if (want.inserted) begin
          stored_count++;
        end else begin
          rejected_count++;
        end
      end
    end
  end

  // The watchdog ends a run that hangs, for example when a result never comes.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned                   phase_caps[12] = '{2, 0, 1, 3, 4, 6, 8, 12, 16, 17, 31, 16};
    logic [lkvc_pkg::KEY_BITS-1:0] key_pool[$];
    logic [lkvc_pkg::KEY_BITS-1:0] k;
    int unsigned                   pool_size;
    int unsigned                   insert_pct;
    int unsigned                   roll;

    // These are the directed cases. A lookup runs on the empty store at reset. Capacity 0 on an
    // empty store accepts an insert and keeps nothing. The extreme keys and values come next,
    // then a duplicate insert that has to leave the value and the recency alone. An insert over
    // the capacity then drops the least recent entry. Next, the capacity is lowered below the
    // count, and nothing may go until the next new key. Last, capacity 31 is set before a new key.
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_cfg(5'd0);
    queue_req(lkvc_pkg::OP_INSERT, 32'h1234_5678, 32'hCAFE_F00D);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    queue_cfg(5'd3);
    queue_req(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(lkvc_pkg::OP_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h8000_0001);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(lkvc_pkg::OP_INSERT, 32'h8000_0000, 32'h0F0F_0F0F);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    queue_cfg(5'd1);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_INSERT, 32'h0000_0009, 32'h7FFF_FFFE);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0009, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
    queue_cfg(5'd31);
    queue_req(lkvc_pkg::OP_INSERT, 32'hDEAD_BEEF, 32'h1111_1111);
    queue_req(lkvc_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000);

    // This is the random part. The entries never leave a net loss: a new key that goes over the
    // capacity drops only one old entry. So the phases mostly raise the capacity from low to high, and
    // each one keeps evicting while the count is still near its limit. Keys come mostly from a
    // small pool per phase, a little larger than the capacity, so that hits, duplicates and
    // evictions all show up often. Every fourth phase runs with no idle cycles at all.
    foreach (phase_caps[p]) begin
      queue_cfg(phase_caps[p][lkvc_pkg::CAP_BITS-1:0]);
      key_pool.delete();
      pool_size = ((phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p]) + $urandom_range(2, 8);
      repeat (pool_size) key_pool.insert(key_pool.size(), $urandom());
      insert_pct = $urandom_range(30, 70);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) queue_drain();
        if (p % 4 != 1) begin
          roll = $urandom_range(0, 99);
          if (roll >= 88) queue_idle($urandom_range(4, 25));
          else if (roll >= 50) queue_idle($urandom_range(1, 3));
        end
        if ($urandom_range(0, 9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        queue_req(($urandom_range(0, 99) < insert_pct) ? lkvc_pkg::OP_INSERT
                                                       : lkvc_pkg::OP_LOOKUP,
                  k, $urandom());
      end
    end

    // Reset is held low and released on a falling edge, away from the sampling edge.
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_steps.size() != 0 || start || expected_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_rsp.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));

    $display("Covered %0d requests: %0d lookup hits, %0d lookup misses, %0d new keys stored,",
             accepted_count, hit_count, miss_count, stored_count);
    $display("%0d duplicate inserts rejected, %0d capacity writes, %0d mismatches.",
             rejected_count, cap_writes, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
